/* rtl/cvo_pkg.sv */
// Shared types, waveform codes and constant lookup tables for the voice oscillator.
// Depends on nothing; every other file of the block imports it.
package cvo_pkg;

	localparam int STEP_BITS       = 24;
	localparam int SAMPLE_BITS     = 16;
	localparam int FULL_SCALE      = 2 ** (SAMPLE_BITS - 1) - 1;
	localparam int SINE_TABLE_SIZE = 256;
	localparam int SINE_IDX_BITS   = $clog2(SINE_TABLE_SIZE);
	localparam int TRI_POS_BITS    = 5;
	localparam int TRI_LEVELS      = 16;
	localparam int WAVE_BITS       = 3;
	localparam int LFSR_BITS       = 15;
	localparam int TAP_PLAIN       = 1;
	localparam int TAP_METAL       = 6;
	localparam int NOISE_SPEED     = 4;
	localparam int WRAP_BITS       = NOISE_SPEED + 1;

	localparam logic [LFSR_BITS-1:0] NOISE_SEED = 15'h4A1;

	localparam logic [WAVE_BITS-1:0] WAVE_SQ12  = 3'd0;
	localparam logic [WAVE_BITS-1:0] WAVE_SQ25  = 3'd1;
	localparam logic [WAVE_BITS-1:0] WAVE_SQ50  = 3'd2;
	localparam logic [WAVE_BITS-1:0] WAVE_TRI   = 3'd3;
	localparam logic [WAVE_BITS-1:0] WAVE_SAW   = 3'd4;
	localparam logic [WAVE_BITS-1:0] WAVE_NOISE = 3'd5;
	localparam logic [WAVE_BITS-1:0] WAVE_METAL = 3'd6;
	localparam logic [WAVE_BITS-1:0] WAVE_SINE  = 3'd7;

	localparam longint PI_Q30 = 64'sd3373259426;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef sample_t sine_rom_t [SINE_TABLE_SIZE];
	typedef sample_t tri_rom_t [TRI_LEVELS];

	typedef struct packed {
		logic init;
		logic clock;
		logic metallic;
	} lfsr_ctrl_t;

	typedef struct packed {
		logic sub;
		logic load;
	} alu_ctrl_t;

	// Quarter-wave folded sine in Q30, Taylor series, scaled to full scale.
	function automatic sine_rom_t build_sine();
		sine_rom_t   rom;
		longint      x;
		longint      s;
		longint      sum;
		logic [63:0] ux;
		logic [63:0] x2;
		logic [63:0] term;
		bit          neg;
		int          k;
		int          i;
		for (k = 0; k < SINE_TABLE_SIZE; k++) begin
			x   = (2 * PI_Q30 * longint'(k)) / SINE_TABLE_SIZE;
			neg = 1'b0;
			if (x > PI_Q30) begin
				x   = x - PI_Q30;
				neg = 1'b1;
			end
			if (x > PI_Q30 / 2)
				x = PI_Q30 - x;
			ux   = 64'(x);
			x2   = (ux * ux) >> 30;
			term = ux;
			sum  = x;
			for (i = 1; i <= 9; i++) begin
				term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
				if (i % 2 == 1)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			if (sum > (64'sd1 <<< 30))
				sum = 64'sd1 <<< 30;
			s = (sum * FULL_SCALE + (64'sd1 <<< 29)) >>> 30;
			rom[k] = neg ? SAMPLE_BITS'(-s) : SAMPLE_BITS'(s);
		end
		return rom;
	endfunction

	// Triangle levels (2L-15)*FS/15, rounded to nearest, halves away from zero.
	function automatic tri_rom_t build_tri();
		tri_rom_t rom;
		longint   num;
		longint   v;
		int       l;
		for (l = 0; l < TRI_LEVELS; l++) begin
			num = longint'(2 * l - 15) * FULL_SCALE;
			if (num >= 0)
				v = (num + 7) / 15;
			else
				v = -((-num + 7) / 15);
			rom[l] = SAMPLE_BITS'(v);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();
	localparam tri_rom_t  TRI_ROM  = build_tri();

endpackage

/* rtl/cvo_alu.sv */
// Shared add/subtract unit with its result register.
// Depends on cvo_pkg for the control struct.
module cvo_alu #(
	parameter int WIDTH = 40
) (
	input  logic               clk,
	input  cvo_pkg::alu_ctrl_t ctrl,
	input  logic [WIDTH-1:0]   a,
	input  logic [WIDTH-1:0]   b,
	output logic [WIDTH-1:0]   y,
	output logic [WIDTH-1:0]   acc_q
);
	import cvo_pkg::*;

	assign y = ctrl.sub ? (a - b) : (a + b);

	always_ff @(posedge clk) begin
		if (ctrl.load)
			acc_q <= y;
	end

endmodule

/* rtl/cvo_lfsr.sv */
// Fifteen-bit noise shift register and the noise level it drives.
// Depends on cvo_pkg for the seed, the taps and the control struct.
module cvo_lfsr (
	input  logic               clk,
	input  logic               arst_n,
	input  cvo_pkg::lfsr_ctrl_t ctrl,
	output logic               positive
);
	import cvo_pkg::*;

	logic [LFSR_BITS-1:0] shift_q;
	logic                 pos_q;
	logic                 fb;
	logic [LFSR_BITS-1:0] shift_next;

	assign fb         = shift_q[0] ^ (ctrl.metallic ? shift_q[TAP_METAL] : shift_q[TAP_PLAIN]);
	assign shift_next = {fb, shift_q[LFSR_BITS-1:1]};
	assign positive   = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= NOISE_SEED;
			pos_q   <= 1'b1;
		end else if (ctrl.init) begin
			shift_q <= NOISE_SEED;
			pos_q   <= 1'b1;
		end else if (ctrl.clock) begin
			shift_q <= shift_next;
			pos_q   <= shift_next[0];
		end
	end

endmodule

/* rtl/cvo_wave.sv */
// Waveform shaper: picks the sample for the current phase from the selected wave.
// Depends on cvo_pkg for codes and the sine and triangle tables.
module cvo_wave #(
	parameter int PHASE_BITS = 24
) (
	input  logic [cvo_pkg::WAVE_BITS-1:0] waveform,
	input  logic [PHASE_BITS-1:0]         phase,
	input  logic                          noise_pos,
	input  cvo_pkg::sample_t              saw_val,
	output cvo_pkg::sample_t              sample
);
	import cvo_pkg::*;

	localparam sample_t POS_FS = SAMPLE_BITS'(FULL_SCALE);
	localparam sample_t NEG_FS = -SAMPLE_BITS'(FULL_SCALE);

	logic [TRI_POS_BITS-1:0]  tri_pos;
	logic [TRI_POS_BITS-2:0]  tri_lvl;
	logic [SINE_IDX_BITS-1:0] sine_idx;

	assign tri_pos  = phase[PHASE_BITS-1 -: TRI_POS_BITS];
	// fold the falling half back onto the rising one
	assign tri_lvl  = tri_pos[TRI_POS_BITS-1] ? ~tri_pos[TRI_POS_BITS-2:0]
	                                          : tri_pos[TRI_POS_BITS-2:0];
	assign sine_idx = phase[PHASE_BITS-1 -: SINE_IDX_BITS];

	always_comb begin
		unique case (waveform)
			WAVE_SQ12:  sample = (phase[PHASE_BITS-1 -: 3] == 3'd0) ? POS_FS : NEG_FS;
			WAVE_SQ25:  sample = (phase[PHASE_BITS-1 -: 2] == 2'd0) ? POS_FS : NEG_FS;
			WAVE_SQ50:  sample = phase[PHASE_BITS-1] ? NEG_FS : POS_FS;
			WAVE_TRI:   sample = TRI_ROM[tri_lvl];
			WAVE_SAW:   sample = saw_val;
			WAVE_NOISE,
			WAVE_METAL: sample = noise_pos ? POS_FS : NEG_FS;
			WAVE_SINE:  sample = SINE_ROM[sine_idx];
			default:    sample = POS_FS;
		endcase
	end

endmodule

/* rtl/chip_voice_oscillator.sv */
// One voice of a chip-style sound generator. Each input word carries a phase step
// (unsigned 0.24 cycle fraction per sample) and a restart flag in tuser; the block
// answers with one signed sample read from the current phase, then advances the phase
// accumulator. The input side is ready only when the previous word has been worked
// through: a word goes through SAW0, SAW1, SAW2, ADV, NOISE and OUT from acceptance
// to the result register, and the input is ready again the cycle after. A single
// shared adder forms the saw ramp in three passes and the phase sum in a fourth; for
// the noise waveforms NOISE then repeats once per accumulator wrap (up to 16), as the
// noise shift register advances once a cycle. A finished sample waits in the output
// register while the next word is worked through; only the hand-over of the next
// sample waits for it to leave.
module chip_voice_oscillator #(
	parameter int PHASE_FRACTION_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cvo_pkg::WAVE_BITS-1:0]     cfg_wdata,      // waveform
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [cvo_pkg::STEP_BITS-1:0]     s_axis_tdata,   // phase_step
	input  logic                              s_axis_tuser,   // restart
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [cvo_pkg::SAMPLE_BITS-1:0]   m_axis_tdata    // sample
);
	import cvo_pkg::*;

	localparam int P     = PHASE_FRACTION_BITS;
	localparam int W     = P + SAMPLE_BITS;
	localparam int SEQ_W = 3;

	localparam logic [SEQ_W-1:0] ST_IDLE  = 3'd0;
	localparam logic [SEQ_W-1:0] ST_SAW0  = 3'd1;
	localparam logic [SEQ_W-1:0] ST_SAW1  = 3'd2;
	localparam logic [SEQ_W-1:0] ST_SAW2  = 3'd3;
	localparam logic [SEQ_W-1:0] ST_ADV   = 3'd4;
	localparam logic [SEQ_W-1:0] ST_NOISE = 3'd5;
	localparam logic [SEQ_W-1:0] ST_OUT   = 3'd6;

	localparam logic [W-1:0] HALF_LSB = W'(1) << (P - 1);
	localparam logic [W-1:0] FS_W     = W'(FULL_SCALE);

	logic [SEQ_W-1:0]     state_q;
	logic [WAVE_BITS-1:0] waveform_q;
	logic [P-1:0]         phase_q;
	logic [P-1:0]         step_q;
	logic [P-1:0]         step_in;
	logic [WRAP_BITS-1:0] wraps_q;
	sample_t              sample_q;
	logic                 out_valid_q;
	sample_t              out_data_q;

	logic                 accept;
	logic                 noise_wave;
	logic                 out_free;
	alu_ctrl_t            alu_ctrl;
	logic [W-1:0]         alu_a;
	logic [W-1:0]         alu_b;
	logic [W-1:0]         alu_y;
	logic [W-1:0]         acc_q;
	lfsr_ctrl_t           lfsr_ctrl;
	logic                 noise_pos;
	sample_t              wave_sample;

	generate
		if (P >= STEP_BITS) begin : g_step_up
			assign step_in = P'(s_axis_tdata) << (P - STEP_BITS);
		end else begin : g_step_down
			assign step_in = s_axis_tdata[STEP_BITS-1 -: P];
		end
	endgenerate

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign noise_wave    = (waveform_q == WAVE_NOISE) || (waveform_q == WAVE_METAL);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// operand selection for the shared adder
	always_comb begin
		alu_ctrl = '{sub: 1'b0, load: 1'b0};
		alu_a    = '0;
		alu_b    = '0;
		unique case (state_q)
			ST_SAW0: begin
				// phase * (2^SB - 2), i.e. phase * 2*FS
				alu_ctrl = '{sub: 1'b1, load: 1'b1};
				alu_a    = {phase_q, {SAMPLE_BITS{1'b0}}};
				alu_b    = W'({phase_q, 1'b0});
			end
			ST_SAW1: begin
				alu_ctrl = '{sub: 1'b0, load: 1'b1};
				alu_a    = acc_q;
				alu_b    = HALF_LSB;
			end
			ST_SAW2: begin
				alu_ctrl = '{sub: 1'b1, load: 1'b1};
				alu_a    = acc_q >> P;
				alu_b    = FS_W;
			end
			ST_ADV: begin
				alu_ctrl = '{sub: 1'b0, load: 1'b0};
				alu_a    = W'(phase_q);
				alu_b    = noise_wave ? W'({step_q, {NOISE_SPEED{1'b0}}}) : W'(step_q);
			end
			ST_IDLE, ST_NOISE, ST_OUT: begin
				alu_ctrl = '{sub: 1'b0, load: 1'b0};
			end
			default: begin
				alu_ctrl = '{sub: 1'b0, load: 1'b0};
			end
		endcase
	end

	always_comb begin
		lfsr_ctrl.init     = accept && s_axis_tuser;
		lfsr_ctrl.clock    = (state_q == ST_NOISE) && (wraps_q != '0);
		lfsr_ctrl.metallic = (waveform_q == WAVE_METAL);
	end

	cvo_alu #(
		.WIDTH (W)
	) u_alu (
		.clk   (clk),
		.ctrl  (alu_ctrl),
		.a     (alu_a),
		.b     (alu_b),
		.y     (alu_y),
		.acc_q (acc_q)
	);

	cvo_lfsr u_lfsr (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (lfsr_ctrl),
		.positive (noise_pos)
	);

	cvo_wave #(
		.PHASE_BITS (P)
	) u_wave (
		.waveform  (waveform_q),
		.phase     (phase_q),
		.noise_pos (noise_pos),
		.saw_val   (acc_q[SAMPLE_BITS-1:0]),
		.sample    (wave_sample)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q <= WAVE_SQ50;
		end else if (cfg_we) begin
			waveform_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			wraps_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_axis_tuser)
							phase_q <= '0;
						state_q <= ST_SAW0;
					end
				end
				ST_SAW0:  state_q <= ST_SAW1;
				ST_SAW1:  state_q <= ST_SAW2;
				ST_SAW2:  state_q <= ST_ADV;
				ST_ADV: begin
					// drop the carry; keep it as a wrap count for noise
					phase_q <= alu_y[P-1:0];
					wraps_q <= noise_wave ? alu_y[P +: WRAP_BITS] : '0;
					state_q <= ST_NOISE;
				end
				ST_NOISE: begin
					if (wraps_q != '0)
						wraps_q <= wraps_q - WRAP_BITS'(1);
					else
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// hold the sample formed from the old phase before the advance lands
	always_ff @(posedge clk) begin
		if (accept)
			step_q <= step_in;
		if (state_q == ST_ADV)
			sample_q <= wave_sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free)
			out_data_q <= sample_q;
	end

endmodule

/* bench/chip_voice_oscillator_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the voice oscillator: keeps its own copy of the voice state, queues the
// sample each accepted word should produce and compares it with the output stream.
// Depends on cvo_pkg for widths, the sample type and the waveform codes.
module chip_voice_oscillator_checker
	import cvo_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [WAVE_BITS-1:0]   cfg_wdata,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [STEP_BITS-1:0]   s_axis_tdata,   // phase_step
	input  logic                   s_axis_tuser,   // restart
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [SAMPLE_BITS-1:0] m_axis_tdata,   // sample
	output int                     errors,
	output int                     pending,
	output int                     checked
);

	localparam longint FULL          = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint HALF_TURN_Q30 = 64'sd3373259426;
	localparam int     SINE_STEPS    = 256;
	localparam int     PLAIN_TAP     = 1;
	localparam int     METAL_TAP     = 6;

	logic [WAVE_BITS-1:0] wave     = WAVE_SQ50;
	logic [23:0]          phase    = '0;
	logic [14:0]          lfsr     = NOISE_SEED;
	logic                 noise_hi = 1'b1;

	sample_t sine_lut [SINE_STEPS];
	sample_t expected_samples [$];
	sample_t want;
	int      mismatch_count = 0;
	int      pending_q      = 0;
	int      checked_q      = 0;

	assign errors  = mismatch_count;
	assign pending = pending_q;
	assign checked = checked_q;

	// Quarter-wave sine in Q30: fold into 0..pi/2, Taylor series to the 19th power.
	function automatic sample_t sine_entry(int k);
		longint ang;
		longint acc;
		longint term;
		longint sq;
		longint mag;
		bit     lower;
		int     n;
		ang   = (2 * HALF_TURN_Q30 * k) / SINE_STEPS;
		lower = ang > HALF_TURN_Q30;
		if (lower)
			ang = ang - HALF_TURN_Q30;
		if (ang > HALF_TURN_Q30 / 2)
			ang = HALF_TURN_Q30 - ang;
		sq   = (ang * ang) >> 30;
		term = ang;
		acc  = ang;
		for (n = 1; n <= 9; n++) begin
			term = ((term * sq) >> 30) / (2 * n * (2 * n + 1));
			acc  = (n % 2 == 1) ? acc - term : acc + term;
		end
		if (acc < 0)
			acc = 0;
		if (acc > (64'sd1 << 30))
			acc = 64'sd1 << 30;
		mag = (acc * FULL + (64'sd1 << 29)) >> 30;
		return lower ? sample_t'(-mag) : sample_t'(mag);
	endfunction

	initial begin
		for (int k = 0; k < SINE_STEPS; k++)
			sine_lut[k] = sine_entry(k);
	end

	function automatic sample_t voice_sample(logic [WAVE_BITS-1:0] w, logic [23:0] ph, logic hi);
		longint lvl;
		longint num;
		longint v;
		v = 0;
		case (w)
			WAVE_SQ12: v = (ph[23:21] == 3'b000) ? FULL : -FULL;
			WAVE_SQ25: v = (ph[23:22] == 2'b00) ? FULL : -FULL;
			WAVE_SQ50: v = !ph[23] ? FULL : -FULL;
			WAVE_TRI: begin
				lvl = longint'(ph[23:19]);
				if (lvl >= 16)
					lvl = 31 - lvl;
				num = (2 * lvl - 15) * FULL;
				v   = (num >= 0) ? (num + 7) / 15 : -((-num + 7) / 15);
			end
			WAVE_SAW: v = ((2 * FULL * longint'(ph) + (64'sd1 << 23)) >>> 24) - FULL;
			WAVE_NOISE, WAVE_METAL: v = hi ? FULL : -FULL;
			default: v = longint'(sine_lut[ph[23:16]]);
		endcase
		return sample_t'(v);
	endfunction

	// Step the accumulator; noise runs sixteen times faster and clocks the LFSR per wrap.
	task automatic advance_voice(logic [23:0] step);
		logic [28:0] sum;
		logic        fb;
		bit          noisy;
		int          tap;
		int          n;
		noisy = (wave == WAVE_NOISE) || (wave == WAVE_METAL);
		tap   = (wave == WAVE_METAL) ? METAL_TAP : PLAIN_TAP;
		sum   = {5'b0, phase} + (noisy ? {1'b0, step, 4'b0} : {5'b0, step});
		phase = sum[23:0];
		if (noisy) begin
			for (n = 0; n < int'(sum[28:24]); n++) begin
				fb       = lfsr[0] ^ lfsr[tap];
				lfsr     = {fb, lfsr[14:1]};
				noise_hi = lfsr[0];
			end
		end
	endtask

	task automatic report_mismatch(string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave     = WAVE_SQ50;
			phase    = '0;
			lfsr     = NOISE_SEED;
			noise_hi = 1'b1;
			expected_samples.delete();
			pending_q <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_samples.size() == 0) begin
					report_mismatch($sformatf("sample %0d with none expected",
						$signed(m_axis_tdata)));
				end else begin
					want = expected_samples.pop_front();
					checked_q++;
					if (sample_t'(m_axis_tdata) !== want)
						report_mismatch($sformatf("sample %0d, expected %0d",
							$signed(m_axis_tdata), want));
				end
			end
			if (cfg_we)
				wave = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) begin
				// restart reseeds the voice before the sample is read
				if (s_axis_tuser) begin
					phase    = '0;
					lfsr     = NOISE_SEED;
					noise_hi = 1'b1;
				end
				expected_samples.push_back(voice_sample(wave, phase, noise_hi));
				advance_voice(s_axis_tdata);
			end
			pending_q <= expected_samples.size();
		end
	end

endmodule

/* bench/chip_voice_oscillator_tb.sv */
`timescale 1ns / 1ps
// Top of the voice oscillator bench: clock, reset, waveform writes and both stream drivers.
// Uses cvo_pkg and the scoreboard in chip_voice_oscillator_checker.sv for the verdict.
module chip_voice_oscillator_tb;
	import cvo_pkg::*;

	localparam int WORDS_PER_SETTING = 50;
	localparam int SETTING_COUNT     = 16;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_we        = 1'b0;
	logic [WAVE_BITS-1:0]   cfg_wdata     = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [STEP_BITS-1:0]   s_axis_tdata  = '0;
	logic                   s_axis_tuser  = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [SAMPLE_BITS-1:0] m_axis_tdata;
	logic                   calm          = 1'b0;

	int mismatches;
	int outstanding;
	int samples_checked;
	int settings_used = 1;

	logic [WAVE_BITS-1:0] wave_order [8] = '{WAVE_SQ12, WAVE_SQ25, WAVE_SQ50, WAVE_TRI,
		WAVE_SAW, WAVE_NOISE, WAVE_METAL, WAVE_SINE};

	chip_voice_oscillator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	chip_voice_oscillator_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.errors        (mismatches),
		.pending       (outstanding),
		.checked       (samples_checked)
	);

	always #6 clk = ~clk;

	initial begin
		#7_200_000;
		$display("FAILURE");
		$finish;
	end

	// Receiver: hold tready low about 9 times in a hundred, never while calm
	always @(posedge clk)
		m_axis_tready <= calm || ($urandom_range(99) >= 9);

	task automatic send_word(logic [STEP_BITS-1:0] step, logic restart);
		if (!calm) begin
			while ($urandom_range(99) < 9) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= step;
		s_axis_tuser  <= restart;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Hold the input until every sample is back, then let the block settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_wave(logic [WAVE_BITS-1:0] w);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	function automatic logic [STEP_BITS-1:0] random_step();
		int pick;
		pick = $urandom_range(9);
		case (pick)
			4, 5, 6: return STEP_BITS'($urandom_range(24'h03FFFF, 1));
			7:       return STEP_BITS'($urandom_range(24'h0FFFFF, 0));
			8: begin
				case ($urandom_range(3))
					0:       return 24'h000000;
					1:       return 24'hFFFFFF;
					2:       return 24'h800000;
					default: return 24'h000001;
				endcase
			end
			9:       return 24'hFFFFFF - STEP_BITS'($urandom_range(255));
			default: return STEP_BITS'($urandom);
		endcase
	endfunction

	initial begin
		int p;
		int i;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset setting is the 50% square
		send_word(24'h000000, 1'b1);
		send_word(24'h000000, 1'b0);
		send_word(24'hFFFFFF, 1'b0);
		send_word(24'h800000, 1'b0);
		send_word(24'h7FFFFF, 1'b0);
		send_word(24'h000001, 1'b0);

		// narrow square right at its edge
		set_wave(WAVE_SQ12);
		send_word(24'h1FFFFF, 1'b1);
		send_word(24'h000001, 1'b0);
		send_word(24'h000001, 1'b0);

		// noise with the most wraps per sample
		set_wave(WAVE_NOISE);
		send_word(24'hFFFFFF, 1'b1);
		send_word(24'hFFFFFF, 1'b0);
		send_word(24'hFFFFFF, 1'b0);
		send_word(24'h000000, 1'b0);
		set_wave(WAVE_METAL);
		send_word(24'hFFFFFF, 1'b1);
		send_word(24'hFFFFFF, 1'b0);
		send_word(24'hFFFFFF, 1'b0);

		// saw at both ends of the ramp
		set_wave(WAVE_SAW);
		send_word(24'hFFFFFF, 1'b1);
		send_word(24'h000001, 1'b0);
		send_word(24'h000000, 1'b0);

		set_wave(WAVE_TRI);
		send_word(24'h780000, 1'b1);
		send_word(24'h080000, 1'b0);
		set_wave(WAVE_SINE);
		send_word(24'h400000, 1'b1);
		send_word(24'h400000, 1'b0);

		for (p = 0; p < SETTING_COUNT; p++) begin
			set_wave(p < 8 ? wave_order[p] : wave_order[$urandom_range(7)]);
			calm <= (p == 5);
			for (i = 0; i < WORDS_PER_SETTING; i++) begin
				if (p == 3 && i == WORDS_PER_SETTING / 2)
					drain();
				send_word(random_step(), $urandom_range(99) < 4);
			end
			calm <= 1'b0;
		end

		drain();
		$display("%0d samples checked across %0d waveform settings", samples_checked,
			settings_used);
		$display("all eight waveforms, restarts, extreme steps and stalls on both streams");
		if (outstanding != 0)
			$display("%0d expected samples never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
rtl/cvo_pkg.sv
rtl/cvo_alu.sv
rtl/cvo_lfsr.sv
rtl/cvo_wave.sv
rtl/chip_voice_oscillator.sv
bench/chip_voice_oscillator_checker.sv
bench/chip_voice_oscillator_tb.sv
